// ===== hw/rtl/pd_pkg.sv =====
// Shared types, constants and helper functions for the percent decoder.
package pd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] ALPHA_BASE = 8'd10;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_DIGIT = 2'd2
   } escape_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end;
   } rsp_type;

   // All results caused by one item
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
      logic                         fin;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_LOWER_A) begin
         v = c - CH_LOWER_A + ALPHA_BASE;
      end else if (c >= CH_UPPER_A) begin
         v = c - CH_UPPER_A + ALPHA_BASE;
      end else begin
         v = c - CH_ZERO;
      end
      return v[3:0];
   endfunction

endpackage

// ===== hw/rtl/pd_front.sv =====
// Front end: tracks the escape state and turns each item that yields results into a result bundle.
module pd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pd_pkg::req_type    req_data,
   output logic               push,
   output pd_pkg::bundle_type push_data,
   input  logic               queue_full
);

   pd_pkg::escape_phase_type phase_ff, phase_in;
   logic [7:0]               held_ff, held_in;
   logic                     accept;
   logic                     do_fresh;
   logic [1:0]               cnt;
   logic [pd_pkg::MAX_RESULTS-1:0][7:0] bytes;
   logic [7:0]               b;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_data.in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pd_pkg::PHASE_IDLE;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      do_fresh = 1'b0;
      cnt      = 2'd0;
      bytes    = '0;

      case (phase_ff)
         pd_pkg::PHASE_PCT: begin
            if (pd_pkg::is_hex(b)) begin
               held_in  = b;
               phase_in = pd_pkg::PHASE_DIGIT;
            end else begin
               bytes[cnt] = pd_pkg::CH_PERCENT;
               cnt        = cnt + 2'd1;
               phase_in   = pd_pkg::PHASE_IDLE;
               do_fresh   = 1'b1;
            end
         end
         pd_pkg::PHASE_DIGIT: begin
            if (pd_pkg::is_hex(b)) begin
               bytes[cnt] = {pd_pkg::nibble(held_ff), pd_pkg::nibble(b)};
               cnt        = cnt + 2'd1;
            end else begin
               bytes[cnt] = pd_pkg::CH_PERCENT;
               cnt        = cnt + 2'd1;
               bytes[cnt] = held_ff;
               cnt        = cnt + 2'd1;
               do_fresh   = 1'b1;
            end
            phase_in = pd_pkg::PHASE_IDLE;
            held_in  = '0;
         end
         default: begin
            phase_in = pd_pkg::PHASE_IDLE;
            do_fresh = 1'b1;
         end
      endcase

      if (do_fresh) begin
         if (b == pd_pkg::CH_PERCENT) begin
            phase_in = pd_pkg::PHASE_PCT;
         end else if (cnt != 2'd3) begin
            bytes[cnt] = (b == pd_pkg::CH_PLUS) ? pd_pkg::CH_SPACE : b;
            cnt        = cnt + 2'd1;
         end
      end

      if (req_data.in_final) begin
         if (phase_in == pd_pkg::PHASE_PCT && cnt != 2'd3) begin
            bytes[cnt] = pd_pkg::CH_PERCENT;
            cnt        = cnt + 2'd1;
         end else if (phase_in == pd_pkg::PHASE_DIGIT && cnt == 2'd0) begin
            bytes[0] = pd_pkg::CH_PERCENT;
            bytes[1] = held_in;
            cnt      = 2'd2;
         end
         phase_in = pd_pkg::PHASE_IDLE;
         held_in  = '0;
      end
   end

   // items that only extend an escape carry no results and are dropped here
   assign push            = accept && (cnt != 2'd0);
   assign push_data.count = cnt;
   assign push_data.bytes = bytes;
   assign push_data.fin   = req_data.in_final;

endmodule

// ===== hw/rtl/pd_queue.sv =====
// Short queue of result bundles between front and back end.
module pd_queue #(
   parameter int unsigned DEPTH = pd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pd_pkg::bundle_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pd_pkg::bundle_type head_data
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   pd_pkg::bundle_type entry_ff [DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pd_back.sv =====
// Back end: sends the bytes of the head bundle one item per cycle while rsp_stall is low.
module pd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  pd_pkg::bundle_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pd_pkg::rsp_type    rsp_data
);

   logic [1:0] index_ff, index_in;
   logic       last;
   logic       take;

   assign last      = (index_ff == head_data.count - 2'd1);
   assign rsp_valid = head_valid;
   assign take      = head_valid && !rsp_stall;
   assign pop       = take && last;

   assign rsp_data.out_byte = (index_ff == 2'd3) ? 8'h00 : head_data.bytes[index_ff];
   assign rsp_data.run_last = last;
   assign rsp_data.text_end = last && head_data.fin;

   always_comb begin
      index_in = index_ff;
      if (take) begin
         index_in = last ? 2'd0 : index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
      end else begin
         index_ff <= index_in;
      end
   end

endmodule

// ===== hw/rtl/percent_decoder_top.sv =====
// Percent decoder top level: streaming URL percent-decoding, one byte per item.
//
// req channel: one encoded byte per item with in_final on the last byte of a text.
// rsp channel: decoded bytes; run_last marks the last result of an input item,
// text_end the last decoded byte of a text. One input gives zero to three results.
// Both channels: item moves on a clock edge with valid high and stall low.
//
// Throughput: one input item per cycle while req_stall is low, one result per
// cycle while rsp_stall is low. An item that releases n results holds the
// back end until all n are sent; the front end keeps taking items until the
// bundle queue (QUEUE_DEPTH entries) is full, and registers each bundle there.
//
// Reset (synchronous, active high) clears the escape state and empties the
// queue. While rsp_stall is high the current result holds; the queue then
// fills and req_stall rises.
module percent_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = pd_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pd_pkg::rsp_type rsp_data
);

   logic               push;
   logic               pop;
   logic               full;
   logic               head_valid;
   pd_pkg::bundle_type push_data;
   pd_pkg::bundle_type head_data;

   pd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (full)
   );

   pd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   pd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
